// ===== rtl/nonce_reuse_guard_defines.svh =====
// assertion macros for the nonce reuse guard
// no dependencies; included by nonce_reuse_guard, the module that carries assertions
`ifndef NONCE_REUSE_GUARD_DEFINES_SVH
`define NONCE_REUSE_GUARD_DEFINES_SVH

`ifndef SYNTH
`define NRG_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("nonce_reuse_guard assertion failed");
`define NRG_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nonce_reuse_guard assertion failed");
`define NRG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nonce_reuse_guard assertion failed");
`else
`define NRG_ASSERT(lbl, expr)
`define NRG_ASSERT_SAME(lbl, ante, cons)
`define NRG_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/nrg_pkg.sv =====
// types, constants and helpers for the nonce reuse guard
// no dependencies; imported by nrg_ram users and nonce_reuse_guard
`default_nettype none

package nrg_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IV_CAPACITY = 16;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int LEN_W = 5;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    localparam logic [1:0] KIND_KEY   = 2'd0;
    localparam logic [1:0] KIND_CHECK = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic REG_GUARD_ENABLE = 1'b0;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  key_byte;
        logic [63:0] iv_low;
        logic [63:0] iv_high;
        logic [7:0]  iv_length;
    } req_t;

    typedef struct packed {
        logic reused;
        logic recorded;
    } rsp_t;

    typedef struct packed {
        logic [31:0]      key_hash;
        logic [LEN_W-1:0] length;
        logic [63:0]      iv_low;
        logic [63:0]      iv_high;
    } entry_t;

    // keeps the first n bytes of a 64-bit word, all of it for n of 8 or more
    function automatic logic [63:0] byte_mask(input logic [LEN_W-1:0] n);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (LEN_W'(b) < n)
            begin
                m[8*b +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/nrg_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module nrg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/nonce_reuse_guard.sv =====
// nonce_reuse_guard: detects reuse of a key hash and iv pair
// requests come in on req (valid/ready), check results leave on rsp (valid/ready).
// a key byte request folds one byte into the running fnv-1a hash.
// a clear request empties the table, resets the cursor and hash.
// a check request walks the table through the entry ram's single read port:
// the scan state reads each entry in turn and compares it, then the resolve
// state writes the result to rsp, records a new pair and returns to idle,
// where the next request is taken. a check with the guard off or an empty or
// oversize iv skips the scan and goes straight to resolve.
// key bytes and clears produce no result. unused kind 3 is dropped.
// the result waits in an output register; key bytes and clears are still
// taken while it waits, a check holds in its final cycle until rsp is free.
// reset: hash to the fnv basis, table empty, cursor 0, guard enabled.
// config: apb register guard_enable at address 0, pready always high.
// depends on nrg_pkg, nrg_ram and nonce_reuse_guard_defines.svh
`default_nettype none
`include "nonce_reuse_guard_defines.svh"

module nonce_reuse_guard
    import nrg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire req_t        req,
    output logic             rsp_valid,
    input  wire logic        rsp_ready,
    output rsp_t             rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_SCAN    = 2'd1;
    localparam logic [1:0] ST_RESOLVE = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [31:0]            hash_reg, hash_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]       ptr_reg, ptr_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   hit_reg, hit_next;
    logic                   skip_reg, skip_next;
    logic                   guard_enable_reg;
    logic                   rsp_valid_reg, rsp_valid_next;

    logic [31:0]            key_hash_reg;
    logic [LEN_W-1:0]       len_reg;
    logic [63:0]            lo_reg;
    logic [63:0]            hi_reg;
    rsp_t                   rsp_reg, rsp_next;

    logic                   req_fire;
    logic                   cfg_write;
    logic                   len_ok;
    logic [LEN_W-1:0]       len_in;
    logic                   slot_free;
    logic                   resolve_go;
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_raddr;
    logic [IDX_W-1:0]       cmp_idx;
    entry_t                 ram_wdata;
    entry_t                 ram_rdata;
    logic                   match;

    nrg_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(TABLE_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ptr_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign slot_free = !rsp_valid_reg || rsp_ready;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_GUARD_ENABLE) ? {31'b0, guard_enable_reg} : 32'b0;

    assign len_ok = (req.iv_length != 8'd0) && (req.iv_length <= 8'(IV_CAPACITY));
    assign len_in = req.iv_length[LEN_W-1:0];

    assign ram_raddr = cnt_reg[IDX_W-1:0];
    assign cmp_idx   = IDX_W'(cnt_reg - 1'b1);
    assign match     = valid_reg[cmp_idx]
                    && (ram_rdata.length == len_reg)
                    && (ram_rdata.key_hash == key_hash_reg)
                    && (ram_rdata.iv_low == lo_reg)
                    && (ram_rdata.iv_high == hi_reg);

    assign resolve_go = (state_reg == ST_RESOLVE) && slot_free;
    assign ram_we     = resolve_go && !skip_reg && !hit_reg;

    assign ram_wdata.key_hash = key_hash_reg;
    assign ram_wdata.length   = len_reg;
    assign ram_wdata.iv_low   = lo_reg;
    assign ram_wdata.iv_high  = hi_reg;

    always_comb
    begin
        state_next     = state_reg;
        hash_next      = hash_reg;
        valid_next     = valid_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        hit_next       = hit_reg;
        skip_next      = skip_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    case (req.kind)
                        KIND_KEY:
                        begin
                            hash_next = (hash_reg ^ {24'b0, req.key_byte}) * FNV_PRIME;
                        end
                        KIND_CHECK:
                        begin
                            hash_next = FNV_BASIS;
                            hit_next  = 1'b0;
                            cnt_next  = '0;
                            skip_next = !guard_enable_reg || !len_ok;
                            state_next = (!guard_enable_reg || !len_ok) ? ST_RESOLVE : ST_SCAN;
                        end
                        KIND_CLEAR:
                        begin
                            hash_next  = FNV_BASIS;
                            valid_next = '0;
                            ptr_next   = '0;
                        end
                        default:
                        begin
                            hash_next = hash_reg;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg != '0)
                begin
                    hit_next = hit_reg || match;
                end
                if (cnt_reg == CNT_W'(TABLE_DEPTH))
                begin
                    state_next = ST_RESOLVE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_RESOLVE:
            begin
                if (slot_free)
                begin
                    rsp_valid_next    = 1'b1;
                    rsp_next.reused   = !skip_reg && hit_reg;
                    rsp_next.recorded = !skip_reg && !hit_reg;
                    if (ram_we)
                    begin
                        valid_next[ptr_reg] = 1'b1;
                        ptr_next = (ptr_reg == IDX_W'(TABLE_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            hash_reg         <= FNV_BASIS;
            valid_reg        <= '0;
            ptr_reg          <= '0;
            cnt_reg          <= '0;
            hit_reg          <= 1'b0;
            skip_reg         <= 1'b0;
            guard_enable_reg <= 1'b1;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            valid_reg     <= valid_next;
            ptr_reg       <= ptr_next;
            cnt_reg       <= cnt_next;
            hit_reg       <= hit_next;
            skip_reg      <= skip_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_write && (paddr[2] == REG_GUARD_ENABLE))
            begin
                guard_enable_reg <= pwdata[0];
            end
        end
    end

    // captured iv and key hash, masked to the iv length
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (req_fire && (req.kind == KIND_CHECK))
        begin
            key_hash_reg <= hash_reg;
            len_reg      <= len_in;
            lo_reg       <= req.iv_low & byte_mask(len_in);
            hi_reg       <= (len_in > LEN_W'(8))
                            ? (req.iv_high & byte_mask(len_in - LEN_W'(8))) : 64'b0;
        end
    end

    `NRG_ASSERT_NEXT(a_check_starts, req_fire && (req.kind == KIND_CHECK), (state_reg == ST_SCAN) || (state_reg == ST_RESOLVE))
    `NRG_ASSERT_NEXT(a_write_sets_valid, ram_we, valid_reg != '0)
    `NRG_ASSERT_SAME(a_scan_bound, state_reg == ST_SCAN, cnt_reg <= CNT_W'(TABLE_DEPTH))
    `NRG_ASSERT_SAME(a_rsp_exclusive, rsp_valid_reg, !(rsp_reg.reused && rsp_reg.recorded))
    `NRG_ASSERT_NEXT(a_rsp_drains, rsp_valid_reg && rsp_ready && (state_reg != ST_RESOLVE), !rsp_valid_reg)

endmodule

`default_nettype wire
